[rtl/rrws_pkg.sv]
// Shared types and constants for the record run window selector.
package rrws_pkg;

    localparam int SEQ_W      = 32;
    localparam int TIME_W     = 64;
    localparam int CNT_W      = 32;
    localparam int TOL_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DAT_W  = 64;
    localparam int US_PER_SEC = 1000000;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(50000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_START = 2'd0,
        CFG_WIN_END   = 2'd1,
        CFG_PRE       = 2'd2,
        CFG_TOL       = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FN_BEGIN  = 2'd0,
        FN_RECORD = 2'd1,
        FN_END    = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_SCAN = 2'd0,
        ST_SEL  = 2'd1,
        ST_NONE = 2'd2,
        ST_IGN  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_BEGIN  = 3'd0,
        K_RECORD = 3'd1,
        K_GAP    = 3'd2,
        K_END    = 3'd3,
        K_IGNORE = 3'd4
    } t_kind;

    typedef struct packed {
        logic signed [TIME_W-1:0] window_start;
        logic signed [TIME_W-1:0] window_end;
        logic                     pre;
        logic [TOL_W-1:0]         tol;
    } t_cfg;

    // Classified item as it sits in the queue.
    typedef struct packed {
        t_kind                    kind;
        logic [SEQ_W-1:0]         seq;
        logic                     seq_max;
        logic signed [TIME_W-1:0] t;
        logic                     too_new;
        logic                     too_old;
    } t_item;

endpackage

[rtl/rrws_front.sv]
// Front end: decodes an incoming header and runs the window bound tests.
module rrws_front (
    input  logic [1:0]                          i_func,
    input  logic                                i_present,
    input  logic [31:0]                         i_seq,
    input  logic signed [rrws_pkg::TIME_W-1:0]  i_record_start_time,
    input  rrws_pkg::t_cfg                      i_cfg,
    output rrws_pkg::t_item                     o_item
);
    import rrws_pkg::*;

    localparam logic signed [TIME_W:0] SEC_X = (TIME_W+1)'(US_PER_SEC);

    logic signed [TIME_W:0] t_plus_sec;
    logic signed [TIME_W:0] start_x;

    always_comb begin
        // exact sum, one bit wider, so the bound test cannot overflow
        t_plus_sec = $signed({i_record_start_time[TIME_W-1], i_record_start_time}) + SEC_X;
        start_x    = $signed({i_cfg.window_start[TIME_W-1], i_cfg.window_start});

        o_item.seq     = i_seq[SEQ_W-1:0];
        o_item.seq_max = &i_seq[SEQ_W-1:0];
        o_item.t       = i_record_start_time;
        o_item.too_new = i_record_start_time >= i_cfg.window_end;
        o_item.too_old = t_plus_sec <= start_x;

        unique case (t_func'(i_func))
            FN_BEGIN:  o_item.kind = K_BEGIN;
            FN_RECORD: o_item.kind = i_present ? K_RECORD : K_GAP;
            FN_END:    o_item.kind = K_END;
            FN_NONE:   o_item.kind = K_IGNORE;
            default:   o_item.kind = K_IGNORE;
        endcase
    end

endmodule

[rtl/rrws_queue.sv]
// Two-entry queue between front and back ends.
module rrws_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  rrws_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output rrws_pkg::t_item o_item,
    input  logic            i_pop
);
    import rrws_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_wr && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

[rtl/rrws_back.sv]
// Back end: run tracking state, run selection and the result register.
module rrws_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rrws_pkg::t_cfg                      i_cfg,
    input  logic                                i_q_valid,
    input  rrws_pkg::t_item                     i_q_item,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic [31:0]                         o_first_seq,
    output logic [31:0]                         o_record_count,
    output logic signed [rrws_pkg::TIME_W-1:0]  o_run_start_time
);
    import rrws_pkg::*;

    localparam logic [TOL_W:0] SEC_T = (TOL_W+1)'(US_PER_SEC);

    // run state
    logic                     r_scanning, n_scanning;
    logic                     r_open,     n_open;
    logic                     r_chosen,   n_chosen;
    logic [SEQ_W-1:0]         r_low_seq,  n_low_seq;
    logic [SEQ_W-1:0]         r_high_seq, n_high_seq;
    logic signed [TIME_W-1:0] r_low_time, n_low_time;
    logic [SEQ_W-1:0]         r_kfs,      n_kfs;
    logic [CNT_W-1:0]         r_kc,       n_kc;
    logic signed [TIME_W-1:0] r_kst,      n_kst;

    // result register
    logic                     r_ov;
    t_status                  r_status;
    logic [31:0]              r_fs;
    logic [31:0]              r_cnt;
    logic signed [TIME_W-1:0] r_rst_time;

    // state as it stands after closing the open run
    logic                     c_chosen;
    logic [SEQ_W-1:0]         c_kfs;
    logic [CNT_W-1:0]         c_kc;
    logic signed [TIME_W-1:0] c_kst;

    logic                     do_close, do_open, do_finish;
    logic [TOL_W:0]           lo, hi;
    logic signed [TIME_W:0]   diff;
    logic                     step_ok, cont;
    t_status                  st;
    logic                     sel;

    assign o_q_pop = i_q_valid && (!r_ov || i_out_ready);

    always_comb begin
        c_chosen = r_chosen;
        c_kfs    = r_kfs;
        c_kc     = r_kc;
        c_kst    = r_kst;
        if (r_open && !(i_cfg.pre && r_chosen)) begin
            c_chosen = 1'b1;
            c_kfs    = r_low_seq;
            c_kc     = CNT_W'(r_high_seq - r_low_seq + SEQ_W'(1));
            c_kst    = r_low_time;
        end

        lo   = ({1'b0, i_cfg.tol} >= SEC_T) ? '0 : SEC_T - {1'b0, i_cfg.tol};
        hi   = SEC_T + {1'b0, i_cfg.tol};
        diff = $signed({r_low_time[TIME_W-1], r_low_time})
             - $signed({i_q_item.t[TIME_W-1], i_q_item.t});
        step_ok = (diff >= $signed({{(TIME_W-TOL_W){1'b0}}, lo}))
               && (diff <= $signed({{(TIME_W-TOL_W){1'b0}}, hi}));
        cont = r_open && !i_q_item.seq_max
            && (SEQ_W'(i_q_item.seq + SEQ_W'(1)) == r_low_seq) && step_ok;

        n_scanning = r_scanning;
        n_open     = r_open;
        n_chosen   = r_chosen;
        n_low_seq  = r_low_seq;
        n_high_seq = r_high_seq;
        n_low_time = r_low_time;
        n_kfs      = r_kfs;
        n_kc       = r_kc;
        n_kst      = r_kst;
        do_close   = 1'b0;
        do_open    = 1'b0;
        do_finish  = 1'b0;
        st         = ST_IGN;

        unique case (i_q_item.kind)
            K_BEGIN: begin
                n_scanning = 1'b1;
                n_open     = 1'b0;
                n_chosen   = 1'b0;
                n_kfs      = '0;
                n_kc       = '0;
                n_kst      = '0;
                st         = ST_SCAN;
            end
            K_GAP: begin
                if (r_scanning) begin
                    do_close = 1'b1;
                    st       = ST_SCAN;
                end
            end
            K_END: begin
                if (r_scanning) begin
                    do_close  = 1'b1;
                    do_finish = 1'b1;
                end
            end
            K_RECORD: begin
                if (r_scanning) begin
                    st = ST_SCAN;
                    priority if (i_q_item.too_new) begin
                        do_close = 1'b1;
                    end else if (i_q_item.too_old) begin
                        do_close  = 1'b1;
                        do_finish = 1'b1;
                    end else if (cont) begin
                        n_low_seq  = i_q_item.seq;
                        n_low_time = i_q_item.t;
                    end else begin
                        do_close = 1'b1;
                        // a pre window stops at the first run it has kept
                        if (i_cfg.pre && c_chosen) begin
                            do_finish = 1'b1;
                        end else begin
                            do_open = 1'b1;
                        end
                    end
                end
            end
            default: st = ST_IGN;
        endcase

        if (do_close) begin
            n_open   = 1'b0;
            n_chosen = c_chosen;
            n_kfs    = c_kfs;
            n_kc     = c_kc;
            n_kst    = c_kst;
        end
        if (do_open) begin
            n_open     = 1'b1;
            n_low_seq  = i_q_item.seq;
            n_high_seq = i_q_item.seq;
            n_low_time = i_q_item.t;
        end
        sel = do_finish && c_chosen && (c_kc != '0);
        if (do_finish) begin
            n_scanning = 1'b0;
            st         = sel ? ST_SEL : ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning <= 1'b0;
            r_open     <= 1'b0;
            r_chosen   <= 1'b0;
            r_low_seq  <= '0;
            r_high_seq <= '0;
            r_low_time <= '0;
            r_kfs      <= '0;
            r_kc       <= '0;
            r_kst      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_scanning <= n_scanning;
                r_open     <= n_open;
                r_chosen   <= n_chosen;
                r_low_seq  <= n_low_seq;
                r_high_seq <= n_high_seq;
                r_low_time <= n_low_time;
                r_kfs      <= n_kfs;
                r_kc       <= n_kc;
                r_kst      <= n_kst;
                r_ov       <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status   <= st;
            r_fs       <= sel ? 32'(c_kfs) : '0;
            r_cnt      <= sel ? 32'(c_kc) : '0;
            r_rst_time <= sel ? c_kst : '0;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_status;
    assign o_first_seq      = r_fs;
    assign o_record_count   = r_cnt;
    assign o_run_start_time = r_rst_time;

endmodule

[rtl/record_run_window_selector.sv]
// Top level of the record run window selector: config registers, front, queue, back.
// An accepted transfer is written into the queue, then popped into the result register.
// Throughput: one item per cycle while the queue has room; the back end retires one queued item per
//   cycle while the result register is empty or being taken.
// A 2-entry queue between front and back lets each side stall independently.
// Reset: synchronous, active low; clears run state, queue and result valid, and sets config to its reset values.
module record_run_window_selector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [rrws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rrws_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic                                i_present,
    input  logic [31:0]                         i_seq,
    input  logic signed [rrws_pkg::TIME_W-1:0]  i_record_start_time,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic [31:0]                         o_first_seq,
    output logic [31:0]                         o_record_count,
    output logic signed [rrws_pkg::TIME_W-1:0]  o_run_start_time
);
    import rrws_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item q_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  in_xfer;

    // Config must only be written while idle (the block does not enforce this), so front and back read it directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start <= '0;
            r_cfg.window_end   <= '0;
            r_cfg.pre          <= 1'b0;
            r_cfg.tol          <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIN_START: r_cfg.window_start <= $signed(i_cfg_data[TIME_W-1:0]);
                CFG_WIN_END:   r_cfg.window_end   <= $signed(i_cfg_data[TIME_W-1:0]);
                CFG_PRE:       r_cfg.pre          <= i_cfg_data[0];
                CFG_TOL:       r_cfg.tol          <= i_cfg_data[TOL_W-1:0];
                default:       r_cfg.pre          <= r_cfg.pre;
            endcase
        end
    end

    // Input is taken whenever the queue has room; it waits on the output only when the queue is full.
    assign o_in_ready = !q_full;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Front: func decode plus the two window bound compares.
    rrws_front u_front (
        .i_func              (i_func),
        .i_present           (i_present),
        .i_seq               (i_seq),
        .i_record_start_time (i_record_start_time),
        .i_cfg               (r_cfg),
        .o_item              (front_item)
    );

    rrws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (in_xfer),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // Back: contiguity step test, run open/close/keep, and the result register.
    rrws_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_first_seq      (o_first_seq),
        .o_record_count   (o_record_count),
        .o_run_start_time (o_run_start_time)
    );

`ifndef NO_ASSERTIONS
    // a selected run always carries a nonzero count
    a_sel_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_SEL) |-> (o_record_count != '0))
        else $error("selected run with zero count");

    // non-selection results carry zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_SEL) |->
            (o_first_seq == '0 && o_record_count == '0 && o_run_start_time == '0))
        else $error("payload on non-selection result");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // queue pops only happen when something is queued
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule
